// ===== rtl/core/srt_pkg.sv =====
package srt_pkg;

  localparam int unsigned OffW = 63;
  localparam int unsigned LenW = 16;
  localparam int unsigned DlenW = 32;
  localparam int unsigned DefaultMaxIntervals = 16;

  localparam logic [OffW-1:0] OffMax = {OffW{1'b1}};
  localparam logic [DlenW-1:0] DlenMax = {DlenW{1'b1}};

  typedef enum logic [0:0] {
    CMD_ADD = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_STALE = 3'd0,
    ST_DELIVERED = 3'd1,
    ST_STORED = 3'd2,
    ST_MERGED = 3'd3,
    ST_FULL = 3'd4,
    ST_RESTART = 3'd5
  } status_e;

  typedef struct packed {
    logic [0:0] cmd;
    logic [OffW-1:0] seg_offset;
    logic [LenW-1:0] seg_length;
  } seg_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [OffW-1:0] deliver_offset;
    logic [DlenW-1:0] deliver_length;
    logic [OffW-1:0] next_offset;
    logic [4:0] pending_count;
    logic [DlenW-1:0] delivered_total;
  } seg_out_t;

  // Work item passed from the front to the back part.
  typedef struct packed {
    logic restart;
    logic [OffW-1:0] off;
    logic [OffW-1:0] seg_end;
  } srt_job_t;

  function automatic logic [OffW-1:0] span_end(logic [OffW-1:0] s, logic [DlenW-1:0] l);
    logic [OffW:0] e;
    e = {1'b0, s} + {{(OffW + 1 - DlenW){1'b0}}, l};
    return e[OffW] ? OffMax : e[OffW-1:0];
  endfunction

endpackage

// ===== rtl/core/segment_reassembly_tracker.sv =====
// Segment reassembly tracker: push (cmd, offset, length) transactions and pop
// one result transaction per pushed item. In-order segments are delivered and
// absorb any stored pending intervals they reach; segments beyond the
// expected offset are merged into a sorted table of up to MaxIntervals entries.
// A restart or stale item passes through the front queue and is resolved by
// the back part straight from its idle state. An add is walked through the
// table by the single-entry scan and shift sequencer and ends in S_DONE,
// unless it finds the table full, which the scan answers itself. The back
// part takes no new job while its result waits to be popped; a two-entry
// queue in front lets new transactions be pushed meanwhile.
module segment_reassembly_tracker
  import srt_pkg::*;
#(
  parameter int unsigned MaxIntervals = DefaultMaxIntervals
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  seg_in_t  seg_i,
  output logic     empty,
  input  logic     pop,
  output seg_out_t result_o
);

  logic job_valid, job_ready;
  srt_job_t job;

  // Front part: accepts and classifies transactions.
  srt_front u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full), .seg_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  // Back part: walks the interval table and produces the result.
  srt_back #(.MaxIntervals(MaxIntervals)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .empty_o(empty), .pop_i(pop), .result_o
  );

endmodule

// ===== rtl/core/srt_front.sv =====
module srt_front
  import srt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  seg_in_t  seg_i,
  output logic     job_valid_o,
  input  logic     job_ready_i,
  output srt_job_t job_o
);

  // Two-entry queue of classified jobs.
  srt_job_t buf_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic rd_q, wr_q;
  logic do_push, do_pop;
  srt_job_t job_new;

  assign full_o = (cnt_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign do_pop = job_valid_o && job_ready_i;
  assign job_o = buf_q[rd_q];

  always_comb begin
    job_new.restart = (seg_i.cmd == CMD_RESTART);
    job_new.off = seg_i.seg_offset;
    job_new.seg_end = span_end(seg_i.seg_offset, {{(DlenW - LenW){1'b0}}, seg_i.seg_length});
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wr_q] <= job_new;
  end

endmodule

// ===== rtl/core/srt_back.sv =====
module srt_back
  import srt_pkg::*;
#(
  parameter int unsigned MaxIntervals = DefaultMaxIntervals
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  output logic     job_ready_o,
  input  srt_job_t job_i,
  output logic     empty_o,
  input  logic     pop_i,
  output seg_out_t result_o
);

  localparam int unsigned IdxW = (MaxIntervals > 1) ? $clog2(MaxIntervals) : 1;
  localparam int unsigned CntW = $clog2(MaxIntervals + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  // Scan modes: in-order delivery, search for the slot, merge with neighbors.
  localparam logic [1:0] M_DELIVER = 2'd0;
  localparam logic [1:0] M_FIND = 2'd1;
  localparam logic [1:0] M_MERGE = 2'd2;

  // Pending table as a sorted register file, shifted one entry per cycle.
  logic [OffW-1:0]  st_q [MaxIntervals];
  logic [DlenW-1:0] ln_q [MaxIntervals];

  logic [2:0] state_q;
  logic [CntW-1:0] count_q;
  logic [OffW-1:0] exp_q;
  logic [DlenW-1:0] total_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] a_q;
  logic a_found_q;
  logic [OffW-1:0] off_q, end_q, old_q;
  logic [1:0] mode_q;
  logic [CntW-1:0] rm_q;  // entries to remove at sh (those merged after a on merge, those absorbed on delivery)
  logic ins_q;
  logic [CntW-1:0] sh_q;
  logic res_valid_q;
  seg_out_t res_q;

  logic [IdxW-1:0] ix;
  logic [IdxW-1:0] ia;
  logic [OffW-1:0] cur_end;
  logic [OffW:0] dsum;
  logic [DlenW-1:0] dsat;
  logic [DlenW:0] tsum;
  logic [OffW-1:0] mlen;

  assign ix = idx_q[IdxW-1:0];
  assign ia = a_q[IdxW-1:0];
  assign cur_end = span_end(st_q[ix], ln_q[ix]);
  assign job_ready_o = (state_q == S_IDLE) && !res_valid_q;
  assign empty_o = !res_valid_q;
  assign result_o = res_q;

  always_comb begin
    dsum = {1'b0, end_q} - {1'b0, old_q};
    dsat = (dsum[OffW-1:DlenW] != '0) ? DlenMax : dsum[DlenW-1:0];
    tsum = {1'b0, total_q} + {1'b0, dsat};
    mlen = end_q - off_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      exp_q <= '0;
      total_q <= '0;
      res_valid_q <= 1'b0;
      idx_q <= '0;
      a_q <= '0;
      a_found_q <= 1'b0;
      mode_q <= M_DELIVER;
      rm_q <= '0;
      ins_q <= 1'b0;
      sh_q <= '0;
    end else begin
      if (pop_i && res_valid_q) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i && !res_valid_q) begin
            off_q <= job_i.off;
            end_q <= job_i.seg_end;
            old_q <= exp_q;
            idx_q <= '0;
            rm_q <= '0;
            a_found_q <= 1'b0;
            ins_q <= 1'b0;
            if (job_i.restart) begin
              exp_q <= job_i.off;
              total_q <= '0;
              res_q <= '{ST_RESTART, '0, '0, job_i.off, 5'(count_q), '0};
              res_valid_q <= 1'b1;
            end else if (job_i.seg_end < exp_q) begin
              res_q <= '{ST_STALE, '0, '0, exp_q, 5'(count_q), total_q};
              res_valid_q <= 1'b1;
            end else if (job_i.off <= exp_q) begin
              mode_q <= M_DELIVER;
              state_q <= S_SCAN;
            end else if (job_i.seg_end == job_i.off) begin
              res_q <= '{ST_STALE, '0, '0, exp_q, 5'(count_q), total_q};
              res_valid_q <= 1'b1;
            end else begin
              mode_q <= M_FIND;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (mode_q == M_DELIVER) begin
            // Absorb head entries reached by the running end.
            if (idx_q < count_q && st_q[ix] <= end_q) begin
              if (cur_end > end_q) end_q <= cur_end;
              idx_q <= idx_q + 1'b1;
            end else begin
              a_q <= '0;
              rm_q <= idx_q;
              sh_q <= '0;
              state_q <= S_SHIFT;
            end
          end else begin
            if (idx_q < count_q && !a_found_q) begin
              if (cur_end >= off_q) begin
                a_found_q <= 1'b1;
                a_q <= idx_q;
                if (st_q[ix] <= end_q) begin
                  if (st_q[ix] < off_q) off_q <= st_q[ix];
                  if (cur_end > end_q) end_q <= cur_end;
                  idx_q <= idx_q + 1'b1;
                  mode_q <= M_MERGE;
                end else begin
                  idx_q <= count_q;
                end
              end else begin
                idx_q <= idx_q + 1'b1;
              end
            end else if (mode_q == M_MERGE && idx_q < count_q && st_q[ix] <= end_q) begin
              if (cur_end > end_q) end_q <= cur_end;
              idx_q <= idx_q + 1'b1;
            end else if (mode_q == M_MERGE) begin
              rm_q <= idx_q - a_q - 1'b1;
              sh_q <= a_q + 1'b1;
              state_q <= S_SHIFT;
            end else begin
              if (!a_found_q) a_q <= count_q;
              if (count_q >= CntW'(MaxIntervals)) begin
                res_q <= '{ST_FULL, '0, '0, exp_q, 5'(count_q), total_q};
                res_valid_q <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                ins_q <= 1'b1;
                sh_q <= count_q;
                state_q <= S_SHIFT;
              end
            end
          end
        end
        S_SHIFT: begin
          if (ins_q) begin
            // Open a slot at a by moving entries up one at a time.
            if (sh_q > a_q) begin
              st_q[sh_q[IdxW-1:0]] <= st_q[IdxW'(sh_q - 1'b1)];
              ln_q[sh_q[IdxW-1:0]] <= ln_q[IdxW'(sh_q - 1'b1)];
              sh_q <= sh_q - 1'b1;
            end else begin
              st_q[ia] <= off_q;
              ln_q[ia] <= mlen[DlenW-1:0];
              count_q <= count_q + 1'b1;
              state_q <= S_DONE;
            end
          end else if (rm_q != '0 && CntW'(sh_q + rm_q) < count_q) begin
            st_q[sh_q[IdxW-1:0]] <= st_q[IdxW'(sh_q + rm_q)];
            ln_q[sh_q[IdxW-1:0]] <= ln_q[IdxW'(sh_q + rm_q)];
            sh_q <= sh_q + 1'b1;
          end else begin
            count_q <= count_q - rm_q;
            if (mode_q == M_MERGE) begin
              st_q[ia] <= off_q;
              ln_q[ia] <= (mlen[OffW-1:DlenW] != '0) ? DlenMax : mlen[DlenW-1:0];
            end
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          state_q <= S_IDLE;
          res_valid_q <= 1'b1;
          if (mode_q == M_DELIVER) begin
            exp_q <= end_q;
            total_q <= tsum[DlenW] ? DlenMax : tsum[DlenW-1:0];
            res_q <= '{ST_DELIVERED, old_q, dsat, end_q, 5'(count_q),
                       tsum[DlenW] ? DlenMax : tsum[DlenW-1:0]};
          end else begin
            res_q <= '{ins_q ? ST_STORED : ST_MERGED, '0, '0, exp_q, 5'(count_q),
                       total_q};
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_segment_reassembly_tracker.sv =====
module tb_segment_reassembly_tracker;
  import srt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TableDepth = 16;
  localparam logic [63:0] OffCeil = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LenCeil = 64'hFFFF_FFFF;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned DrainCycles = 60;

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  seg_in_t seg_i;
  logic empty;
  logic pop;
  seg_out_t result_o;

  segment_reassembly_tracker #(
    .MaxIntervals(TableDepth)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .seg_i(seg_i),
    .empty(empty),
    .pop(pop),
    .result_o(result_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Tracker state as the testbench predicts it. Offsets are kept in 64 bits so
  // that sums never wrap before they are clamped to the 63-bit ceiling.
  logic [63:0] exp_next;
  logic [63:0] exp_total;
  logic [63:0] pend_start[TableDepth];
  logic [63:0] pend_len[TableDepth];
  int unsigned pend_cnt;

  // Predicted result transactions, oldest first.
  seg_out_t expected_results[$];

  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned status_hits[6];
  bit long_hold;

  function automatic logic [63:0] clamp_end(logic [63:0] s, logic [63:0] l);
    logic [63:0] e;
    e = s + l;
    return (e > OffCeil) ? OffCeil : e;
  endfunction

  function automatic void drop_entries(int unsigned first, int unsigned n);
    for (int unsigned i = first; i + n < pend_cnt; i++) begin
      pend_start[i] = pend_start[i + n];
      pend_len[i] = pend_len[i + n];
    end
    pend_cnt -= n;
  endfunction

  // Places an out-of-order segment into the sorted table, merging with any
  // entry that it overlaps or touches.
  function automatic status_e file_segment(logic [63:0] off, logic [63:0] seg_end);
    int unsigned a;
    int unsigned b;
    logic [63:0] ns;
    logic [63:0] ne;
    logic [63:0] be;
    logic [63:0] span;
    a = 0;
    while (a < pend_cnt && clamp_end(pend_start[a], pend_len[a]) < off) a++;
    if (a < pend_cnt && pend_start[a] <= seg_end) begin
      b = a;
      while (b + 1 < pend_cnt && pend_start[b + 1] <= seg_end) b++;
      ns = (off < pend_start[a]) ? off : pend_start[a];
      be = clamp_end(pend_start[b], pend_len[b]);
      ne = (seg_end > be) ? seg_end : be;
      span = ne - ns;
      pend_start[a] = ns;
      pend_len[a] = (span > LenCeil) ? LenCeil : span;
      drop_entries(a + 1, b - a);
      return ST_MERGED;
    end
    if (pend_cnt >= TableDepth) return ST_FULL;
    for (int unsigned i = pend_cnt; i > a; i--) begin
      pend_start[i] = pend_start[i - 1];
      pend_len[i] = pend_len[i - 1];
    end
    pend_start[a] = off;
    pend_len[a] = seg_end - off;
    pend_cnt++;
    return ST_STORED;
  endfunction

  function automatic seg_out_t track_segment(seg_in_t item);
    seg_out_t r;
    logic [63:0] off;
    logic [63:0] seg_end;
    logic [63:0] reach;
    logic [63:0] gained;
    logic [63:0] e;
    status_e st;
    off = {1'b0, item.seg_offset};
    r = '0;
    if (item.cmd == CMD_RESTART) begin
      exp_next = off;
      exp_total = 0;
      st = ST_RESTART;
    end else begin
      seg_end = clamp_end(off, {48'd0, item.seg_length});
      if (seg_end < exp_next) begin
        st = ST_STALE;
      end else if (off <= exp_next) begin
        reach = seg_end;
        while (pend_cnt > 0 && pend_start[0] <= reach) begin
          e = clamp_end(pend_start[0], pend_len[0]);
          if (e > reach) reach = e;
          drop_entries(0, 1);
        end
        gained = reach - exp_next;
        r.deliver_offset = exp_next[62:0];
        r.deliver_length = (gained > LenCeil) ? DlenMax : gained[31:0];
        exp_total = (gained > LenCeil - exp_total) ? LenCeil : exp_total + gained;
        exp_next = reach;
        st = ST_DELIVERED;
      end else if (seg_end == off) begin
        st = ST_STALE;
      end else begin
        st = file_segment(off, seg_end);
      end
    end
    r.status = st;
    r.next_offset = exp_next[62:0];
    r.pending_count = pend_cnt[4:0];
    r.delivered_total = exp_total[31:0];
    return r;
  endfunction

  initial begin
    push = 1'b0;
    seg_i = '0;
    rst_ni = 1'b0;
    exp_next = 0;
    exp_total = 0;
    pend_cnt = 0;
    for (int i = 0; i < TableDepth; i++) begin
      pend_start[i] = 0;
      pend_len[i] = 0;
    end
  end

  // Sender: offers one transaction after a random gap and holds it until the
  // block takes it. The prediction is made at the accepting edge. With no gap,
  // push simply stays high into the next transaction.
  task automatic send_item(logic cmd, logic [62:0] off, logic [15:0] len, bit no_gap = 0);
    seg_in_t item;
    int unsigned gap;
    item.cmd = cmd;
    item.seg_offset = off;
    item.seg_length = len;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
    if ($urandom_range(0, 9) < 3) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    seg_i <= item;
    do @(posedge clk_i); while (full);
    expected_results.push_back(track_segment(item));
    items_sent++;
  endtask

  // Receiver: pops with random stalls, and once holds off for a long stretch.
  int unsigned pop_wait;
  initial begin
    pop = 1'b0;
    pop_wait = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        check_result(result_o);
        pop_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 9) < 3) pop_wait = 0;
      end
      if (long_hold) begin
        pop <= 1'b0;
        for (int unsigned c = 0; c < LongHoldCycles; c++) @(posedge clk_i);
        long_hold = 0;
        pop_wait = 0;
      end
      if (pop_wait > 0) begin
        pop <= 1'b0;
        pop_wait--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic check_result(seg_out_t got);
    seg_out_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("Unexpected result transaction: %p", got);
    end else begin
      want = expected_results.pop_front();
      if (want.status < 6) status_hits[want.status]++;
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Result %0d differs: status exp %0d got %0d", results_seen,
                   want.status, got.status);
          $display("  deliver_offset exp %h got %h, deliver_length exp %h got %h",
                   want.deliver_offset, got.deliver_offset,
                   want.deliver_length, got.deliver_length);
          $display("  next_offset exp %h got %h, pending_count exp %0d got %0d",
                   want.next_offset, got.next_offset,
                   want.pending_count, got.pending_count);
          $display("  delivered_total exp %h got %h",
                   want.delivered_total, got.delivered_total);
        end
      end
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Directed: extremes of the fields and each special case in turn.
  task automatic test_directed();
    send_item(CMD_ADD, 63'd0, 16'd0);           // zero-length at expected: in-order path
    send_item(CMD_ADD, 63'd0, 16'd100);         // plain in-order delivery
    send_item(CMD_ADD, 63'd10, 16'd20);         // stale segment
    send_item(CMD_ADD, 63'd100, 16'd0);         // ends exactly at expected offset
    send_item(CMD_ADD, 63'd500, 16'd0);         // empty segment beyond expected
    send_item(CMD_ADD, 63'd300, 16'd50);        // stored new
    send_item(CMD_ADD, 63'd200, 16'd50);        // stored in front
    send_item(CMD_ADD, 63'd250, 16'd50);        // touches both neighbors: merge
    send_item(CMD_ADD, 63'd90, 16'd120);        // overlap, absorbs the table
    send_item(CMD_RESTART, 63'd1000, 16'hFFFF); // restart
    send_item(CMD_ADD, 63'd1100, 16'd10);
    send_item(CMD_RESTART, 63'd2000, 16'd0);    // restart past a pending interval
    send_item(CMD_ADD, 63'd2000, 16'd5);        // stale entry absorbed on delivery
    send_item(CMD_RESTART, 63'h7FFF_FFFF_FFFF_FF00, 16'd0);
    send_item(CMD_ADD, 63'h7FFF_FFFF_FFFF_FFF0, 16'hFFFF); // offset ceiling
    send_item(CMD_ADD, 63'h7FFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_item(CMD_RESTART, 63'd0, 16'd0);
    // Fill the table with gapped intervals, then overflow it.
    for (int i = 0; i < 17; i++) send_item(CMD_ADD, 63'(100 + 20 * i), 16'd10);
    send_item(CMD_ADD, 63'd0, 16'd100);         // absorbs the first, at offset 100
    wait_drained();
  endtask

  // Long segments: maximum-length segments spread far apart, sent back to
  // back, fill the table and overflow it; a one-byte delivery then absorbs
  // the first of them.
  task automatic test_saturation();
    send_item(CMD_RESTART, 63'd0, 16'd0);
    for (int i = 0; i < 66000; i += 600)
      send_item(CMD_ADD, 63'(64'd1 + 64'(i) * 64'd65535), 16'hFFFF, 1);
    send_item(CMD_ADD, 63'd0, 16'd1);
    wait_drained();
  endtask

  // Random: well-formed streams of nearby segments around the expected offset,
  // with a share of restarts and arbitrary offsets as noise.
  task automatic test_random(int unsigned count);
    logic [62:0] off;
    logic [15:0] len;
    logic [62:0] base;
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      base = exp_next[62:0];
      len = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
      if (pick < 3) begin
        send_item(CMD_RESTART, 63'({$urandom, $urandom}), 16'($urandom));
      end else if (pick < 6) begin
        send_item(CMD_RESTART, 63'($urandom_range(0, 400)), len);
      end else if (pick < 10) begin
        send_item(CMD_ADD, 63'({$urandom, $urandom}), len);
      end else if (pick < 20) begin
        off = (base > 63'd100) ? base - 63'($urandom_range(0, 100)) : 63'd0;
        send_item(CMD_ADD, off, len);
      end else begin
        send_item(CMD_ADD, base + 63'($urandom_range(0, 600)), len);
      end
    end
  endtask

  // Pressure: the receiver stalls while the sender keeps offering items.
  task automatic test_backpressure();
    long_hold = 1;
    for (int i = 0; i < 12; i++)
      send_item(CMD_ADD, exp_next[62:0] + 63'($urandom_range(0, 200)), 16'd8, 1);
    wait_drained();
  endtask

  initial begin
    mismatch_count = 0;
    items_sent = 0;
    results_seen = 0;
    long_hold = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_saturation();
    test_backpressure();
    test_random(920);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d segment transactions, checked %0d results.", items_sent, results_seen);
    $display("Status counts stale %0d delivered %0d stored %0d merged %0d full %0d restart %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5]);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: about 1200 items in the worst case, taken several times over.
  initial begin
    #(20ns * 600000);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/srt_pkg.sv
rtl/core/srt_front.sv
rtl/core/srt_back.sv
rtl/core/segment_reassembly_tracker.sv
tb/sv/tb_segment_reassembly_tracker.sv
